>>> rtl/kit_pkg.sv
// Shared types, constants and helper functions for the keyword/identifier tokenizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package kit_pkg;

   // Token text capacity in bytes (2..8) and width of the line counter (8..32).
   localparam int TEXT_BYTES  = 8;
   localparam int LINE_WIDTH  = 16;
   localparam int LINE_EXT_W  = (LINE_WIDTH > 16) ? LINE_WIDTH : 16;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic [63:0] KW_LET = 64'h0000_0000_0074_656C;
   localparam logic [63:0] KW_VAR = 64'h0000_0000_0072_6176;
   localparam logic [63:0] KW_FN  = 64'h0000_0000_0000_6E66;

   typedef enum logic [4:0] {
      KIND_EOF    = 5'd0,
      KIND_LET    = 5'd1,
      KIND_VAR    = 5'd2,
      KIND_FN     = 5'd3,
      KIND_IDENT  = 5'd4,
      KIND_NUMBER = 5'd5,
      KIND_ASSIGN = 5'd6,
      KIND_PLUS   = 5'd7,
      KIND_MINUS  = 5'd8,
      KIND_STAR   = 5'd9,
      KIND_SLASH  = 5'd10,
      KIND_SEMI   = 5'd11,
      KIND_LPAREN = 5'd12,
      KIND_RPAREN = 5'd13,
      KIND_LBRACE = 5'd14,
      KIND_RBRACE = 5'd15,
      KIND_COLON  = 5'd16
   } kind_type;

   // Scanner state, one-hot.
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_IDENT  = 3'b010,
      MODE_NUMBER = 3'b100
   } mode_type;

   // Result slots of one bundle, in delivery order.
   typedef enum logic [1:0] {
      SLOT_FLUSH  = 2'd0,
      SLOT_SINGLE = 2'd1,
      SLOT_EOF    = 2'd2
   } slot_type;

   // Everything one source byte produces: a flushed token, a one-byte token, EOF.
   typedef struct packed {
      logic        has_flush;
      kind_type    flush_kind;
      logic [63:0] flush_text;
      logic [7:0]  flush_len;
      logic        flush_trunc;
      logic        has_single;
      kind_type    single_kind;
      logic [7:0]  single_byte;
      logic        has_eof;
      logic [15:0] line_pre;
      logic [15:0] line_post;
   } bundle_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39);
   endfunction

   // Punctuation kind, KIND_EOF when the byte is no punctuation.
   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         8'h3D:   k = KIND_ASSIGN;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h3B:   k = KIND_SEMI;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h3A:   k = KIND_COLON;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   // Clamp the line counter to the 16-bit output field.
   function automatic logic [15:0] sat_line(input logic [LINE_WIDTH-1:0] v);
      logic [LINE_EXT_W-1:0] ext;
      ext = LINE_EXT_W'(v);
      return (ext > LINE_EXT_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/kit_front.sv
// Front end of the tokenizer: scanner state, byte classification and bundle build.
// Depends on kit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kit_front
   import kit_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] ch,
   input  wire logic       last,
   output logic            push,
   output bundle_type      bundle
);

   mode_type                mode_ff, mode_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [63:0]             text_ff, text_in;
   logic [7:0]              len_ff, len_in;

   logic                    letter, digit, fin, append, start;
   kind_type                pk, start_kind, flush_kind;
   logic [63:0]             text_app, flush_text;
   logic [7:0]              len_app, flush_len;
   logic                    flush_trunc;
   logic [LINE_WIDTH-1:0]   line_next;

   always_comb begin
      letter = is_letter(ch);
      digit  = is_digit(ch);
      pk     = punct_kind(ch);
      fin    = last || (ch == CH_NUL);
      append = ((mode_ff == MODE_IDENT) && (letter || digit)) ||
               ((mode_ff == MODE_NUMBER) && digit);
      start      = !append && (letter || digit);
      start_kind = letter ? KIND_IDENT : KIND_NUMBER;

      // Place the byte at the current length while it still fits.
      text_app = text_ff;
      for (int i = 0; i < TEXT_BYTES; i++) begin
         if (len_ff == 8'(i)) begin
            text_app[8*i +: 8] = ch;
         end
      end
      len_app = (len_ff == 8'hFF) ? 8'hFF : len_ff + 8'd1;

      flush_text  = append ? text_app : text_ff;
      flush_len   = append ? len_app : len_ff;
      flush_trunc = (flush_len > 8'(TEXT_BYTES));
      flush_kind  = KIND_NUMBER;
      if (mode_ff == MODE_IDENT) begin
         flush_kind = KIND_IDENT;
         if (!flush_trunc && flush_len == 8'd3 && flush_text == KW_LET) begin
            flush_kind = KIND_LET;
         end else if (!flush_trunc && flush_len == 8'd3 && flush_text == KW_VAR) begin
            flush_kind = KIND_VAR;
         end else if (!flush_trunc && flush_len == 8'd2 && flush_text == KW_FN) begin
            flush_kind = KIND_FN;
         end
      end

      line_next = line_ff;
      if (!append && ch == CH_LF && line_ff != {LINE_WIDTH{1'b1}}) begin
         line_next = line_ff + LINE_WIDTH'(1);
      end

      bundle.has_flush   = (mode_ff != MODE_IDLE) && (!append || fin);
      bundle.flush_kind  = flush_kind;
      bundle.flush_text  = flush_text;
      bundle.flush_len   = flush_len;
      bundle.flush_trunc = flush_trunc;
      // A token started on the final byte is flushed at once as a one-byte token.
      bundle.has_single  = !append && ((start && fin) || (pk != KIND_EOF));
      bundle.single_kind = start ? start_kind : pk;
      bundle.single_byte = ch;
      bundle.has_eof     = fin;
      bundle.line_pre    = sat_line(line_ff);
      bundle.line_post   = sat_line(line_next);

      push = accept && (bundle.has_flush || bundle.has_single || bundle.has_eof);

      mode_in = mode_ff;
      line_in = line_ff;
      text_in = text_ff;
      len_in  = len_ff;
      if (accept) begin
         priority if (fin) begin
            mode_in = MODE_IDLE;
            line_in = LINE_WIDTH'(1);
            text_in = '0;
            len_in  = '0;
         end else if (append) begin
            text_in = text_app;
            len_in  = len_app;
            line_in = line_next;
         end else if (start) begin
            mode_in = letter ? MODE_IDENT : MODE_NUMBER;
            text_in = {56'd0, ch};
            len_in  = 8'd1;
            line_in = line_next;
         end else begin
            mode_in = MODE_IDLE;
            text_in = '0;
            len_in  = '0;
            line_in = line_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_WIDTH'(1);
         text_ff <= '0;
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         text_ff <= text_in;
         len_ff  <= len_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kit_queue.sv
// Short bundle queue that decouples the tokenizer front end from the emitter.
// Depends on kit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kit_queue
   import kit_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  bundle_type      push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            head_valid,
   output bundle_type      head
);

   bundle_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head       = entry_ff[rd_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kit_back.sv
// Back end of the tokenizer: walks the slots of each bundle into the result register.
// Depends on kit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kit_back
   import kit_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  bundle_type       head,
   output logic             pop,
   output logic             out_valid,
   input  wire logic        out_ready,
   output kind_type         out_kind,
   output logic [15:0]      out_line,
   output logic [63:0]      out_text,
   output logic [7:0]       out_len,
   output logic             out_trunc,
   output logic             out_last
);

   slot_type      phase_ff, phase_in, sel;
   logic          valid_ff, valid_in;
   kind_type      kind_ff, kind_in;
   logic [15:0]   line_ff, line_in;
   logic [63:0]   text_ff, text_in;
   logic [7:0]    len_ff, len_in;
   logic          trunc_ff, trunc_in, last_ff, last_in;
   logic [2:0]    present, remain;
   logic          load, more;

   always_comb begin
      present = {head.has_eof, head.has_single, head.has_flush};
      unique case (phase_ff)
         SLOT_FLUSH:  remain = present;
         SLOT_SINGLE: remain = present & 3'b110;
         SLOT_EOF:    remain = present & 3'b100;
         default:     remain = present;
      endcase

      priority if (remain[0]) begin
         sel  = SLOT_FLUSH;
         more = remain[1] || remain[2];
      end else if (remain[1]) begin
         sel  = SLOT_SINGLE;
         more = remain[2];
      end else begin
         sel  = SLOT_EOF;
         more = 1'b0;
      end

      load = head_valid && (!valid_ff || out_ready);
      pop  = load && !more;

      valid_in = valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      line_in  = line_ff;
      text_in  = text_ff;
      len_in   = len_ff;
      trunc_in = trunc_ff;
      last_in  = last_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in  = !more;
         phase_in = more ? slot_type'(sel + 2'd1) : SLOT_FLUSH;
         unique case (sel)
            SLOT_FLUSH: begin
               kind_in  = head.flush_kind;
               line_in  = head.line_pre;
               text_in  = head.flush_text;
               len_in   = head.flush_len;
               trunc_in = head.flush_trunc;
            end
            SLOT_SINGLE: begin
               kind_in  = head.single_kind;
               line_in  = head.line_pre;
               text_in  = {56'd0, head.single_byte};
               len_in   = 8'd1;
               trunc_in = 1'b0;
            end
            default: begin
               kind_in  = KIND_EOF;
               line_in  = head.line_post;
               text_in  = '0;
               len_in   = '0;
               trunc_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= SLOT_FLUSH;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      line_ff  <= line_in;
      text_ff  <= text_in;
      len_ff   <= len_in;
      trunc_ff <= trunc_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_line  = line_ff;
   assign out_text  = text_ff;
   assign out_len   = len_ff;
   assign out_trunc = trunc_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

>>> rtl/keyword_identifier_tokenizer.sv
// Top level of the keyword/identifier tokenizer: front end, bundle queue, emitter.
// Depends on kit_pkg, kit_front, kit_queue and kit_back.
//
// One ASCII source byte enters per request on req_*; tokens leave one per
// request on rsp_*. Space, tab and CR are skipped, LF advances the line count,
// identifiers (checked against let, var and fn) and decimal numbers are
// gathered across bytes, and = + - * / ; ( ) { } : give one-byte tokens. A zero
// byte or req_tlast ends the source: the pending token goes out, then an EOF
// token, and the scanner returns to its reset state. Token text keeps the first
// TEXT_BYTES bytes; longer tokens carry their saturated length and the
// truncated flag. rsp_tlast marks the last token caused by one source byte.
// Rate: the front end takes a byte every cycle as long as the four-entry
// queue has room; the emitter sends one token per cycle while rsp_tready is
// high, a byte causes 0 to 3 tokens, and the sustained rate is one byte per
// cycle for sources with at most one token per byte while rsp_tready is high.
// A token passes through the queue and then the result register on its way out.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module keyword_identifier_tokenizer
   import kit_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: source byte
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tlast,   // last byte of the source
   // Response: tokens
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // [15:0] line_number, [79:16] token_text,
                                         // [87:80] text_length, [88] truncated, rest zero
   output logic [4:0]       rsp_tuser,   // [4:0] token_kind
   output logic             rsp_tlast    // last token of one source byte
);

   logic          accept, push, full, pop, head_valid;
   bundle_type    bundle, head;
   kind_type      out_kind;
   logic [15:0]   out_line;
   logic [63:0]   out_text;
   logic [7:0]    out_len;
   logic          out_trunc;

   // Take a byte whenever the queue has room; a byte with no tokens is just absorbed.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   kit_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_tdata),
      .last   (req_tlast),
      .push   (push),
      .bundle (bundle)
   );

   kit_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (bundle),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   kit_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (out_kind),
      .out_line   (out_line),
      .out_text   (out_text),
      .out_len    (out_len),
      .out_trunc  (out_trunc),
      .out_last   (rsp_tlast)
   );

   // Pack the token fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {7'd0, out_trunc, out_len, out_text, out_line};
   assign rsp_tuser = out_kind;

endmodule

`default_nettype wire

>>> verif/keyword_identifier_tokenizer_checker.sv
`timescale 1ns / 1ps
// Token checker for the keyword/identifier tokenizer: mirrors the scanner per request
// and compares every response field by field. Depends on kit_pkg.
module keyword_identifier_tokenizer_checker
   import kit_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [95:0] rsp_tdata,
   input  wire logic [4:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               mismatches,
   output int               pending_tokens
);

   typedef struct {
      kind_type    kind;
      logic [15:0] line;
      logic [63:0] text;
      logic [7:0]  length;
      logic        trunc;
      logic        last;
   } token_rec_type;

   token_rec_type         expected_tokens[$];
   mode_type              scan_mode;
   logic [LINE_WIDTH-1:0] line_count;
   logic [63:0]           word_text;
   logic [7:0]            word_len;
   int                    run_count;

   function automatic logic word_start(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic decimal(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic single_token(input logic [7:0] c, output kind_type k);
      logic hit;
      hit = 1'b1;
      k   = KIND_EOF;
      case (c)
         "=":     k = KIND_ASSIGN;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ":":     k = KIND_COLON;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   task clear_scanner();
      scan_mode  = MODE_IDLE;
      line_count = LINE_WIDTH'(1);
      word_text  = '0;
      word_len   = '0;
   endtask

   task push_token(input kind_type kind, input logic [63:0] text, input logic [7:0] length,
                   input logic trunc);
      token_rec_type tok;
      tok.kind   = kind;
      tok.line   = (64'(line_count) > 64'hFFFF) ? 16'hFFFF : 16'(line_count);
      tok.text   = text;
      tok.length = length;
      tok.trunc  = trunc;
      tok.last   = 1'b0;
      expected_tokens.push_back(tok);
      run_count++;
   endtask

   task append_byte(input logic [7:0] c);
      if (word_len < TEXT_BYTES)
         word_text[8*word_len +: 8] = c;
      if (word_len != 8'd255)
         word_len++;
   endtask

   // Close the identifier or number in progress, if any.
   task flush_word();
      logic     trunc;
      kind_type kind;
      if (scan_mode == MODE_IDENT || scan_mode == MODE_NUMBER) begin
         trunc = word_len > TEXT_BYTES;
         kind  = KIND_NUMBER;
         if (scan_mode == MODE_IDENT) begin
            kind = KIND_IDENT;
            if (!trunc && word_len == 8'd3 && word_text == KW_LET)
               kind = KIND_LET;
            else if (!trunc && word_len == 8'd3 && word_text == KW_VAR)
               kind = KIND_VAR;
            else if (!trunc && word_len == 8'd2 && word_text == KW_FN)
               kind = KIND_FN;
         end
         push_token(kind, word_text, word_len, trunc);
      end
      scan_mode = MODE_IDLE;
      word_text = '0;
      word_len  = '0;
   endtask

   task tokenize_byte(input logic [7:0] c, input logic fin);
      logic          done;
      kind_type      pk;
      token_rec_type tok;
      run_count = 0;
      done      = fin;
      if (scan_mode == MODE_IDENT && (word_start(c) || decimal(c))) begin
         append_byte(c);
      end else if (scan_mode == MODE_NUMBER && decimal(c)) begin
         append_byte(c);
      end else begin
         flush_word();
         if (c == CH_NUL) begin
            done = 1'b1;
         end else if (c == CH_LF) begin
            if (line_count != '1)
               line_count++;
         end else if (word_start(c) || decimal(c)) begin
            scan_mode = word_start(c) ? MODE_IDENT : MODE_NUMBER;
            word_text = {56'b0, c};
            word_len  = 8'd1;
         end else if (single_token(c, pk)) begin
            push_token(pk, {56'b0, c}, 8'd1, 1'b0);
         end
      end
      if (done) begin
         flush_word();
         push_token(KIND_EOF, '0, '0, 1'b0);
         clear_scanner();
      end
      if (run_count > 0) begin
         tok      = expected_tokens.pop_back();
         tok.last = 1'b1;
         expected_tokens.push_back(tok);
      end
   endtask

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t tokenizer: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      token_rec_type want;
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready)
            tokenize_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("token with nothing predicted, kind", 64'(rsp_tuser), 64'd0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("token_kind", 64'(rsp_tuser), 64'(want.kind));
               if (rsp_tdata[15:0] !== want.line)
                  report_mismatch("line_number", 64'(rsp_tdata[15:0]), 64'(want.line));
               if (rsp_tdata[79:16] !== want.text)
                  report_mismatch("token_text", rsp_tdata[79:16], want.text);
               if (rsp_tdata[87:80] !== want.length)
                  report_mismatch("text_length", 64'(rsp_tdata[87:80]), 64'(want.length));
               if (rsp_tdata[88] !== want.trunc)
                  report_mismatch("truncated", 64'(rsp_tdata[88]), 64'(want.trunc));
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_run", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
      pending_tokens = expected_tokens.size();
   end

endmodule

>>> verif/keyword_identifier_tokenizer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the keyword/identifier tokenizer: drives source bytes and token
// back-pressure, gives the verdict. Depends on kit_pkg and keyword_identifier_tokenizer_checker.
module keyword_identifier_tokenizer_tb;
   import kit_pkg::*;

   // No-progress limit: far above the longest hold-off plus the sparsest stall pattern.
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_BYTES    = 55;
   // Long enough to overflow the text capacity of a token.
   localparam int LONG_TAIL       = 10;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } stall_style_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [95:0] rsp_tdata;
   wire  [4:0]  rsp_tuser;
   wire         rsp_tlast;

   int mismatches;
   int pending_tokens;
   int burst_left      = 0;
   int bytes_sent      = 0;
   int idle_cycles     = 0;
   bit squeeze_request = 1'b0;
   bit squeeze_done    = 1'b0;

   keyword_identifier_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   keyword_identifier_tokenizer_checker checker_0 (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatches     (mismatches),
      .pending_tokens (pending_tokens)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort when neither channel moves for too long: a hung block or a lost token.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Token receiver: switch among random stall styles, and hold off once
   // for a long stretch so the queue fills and the block stalls its request side.
   initial begin
      stall_style_type style;
      int              style_left;
      style      = READY_ALWAYS;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (squeeze_request && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (style_left == 0) begin
               style      = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(16, 96);
            end
            style_left--;
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               READY_TOGGLE: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   // Offer one source byte and hold it until the block takes it. Between bursts,
   // drop valid for a random gap; a zero gap keeps the stream back to back.
   task send_byte(input logic [7:0] c, input logic mark_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= mark_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task send_text(input string s, input logic mark_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], mark_last && i == s.len() - 1);
   endtask

   initial begin
      string alnum;
      string puncts;
      string blanks;
      int    start_count;
      int    pick;
      int    n;
      alnum  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      puncts = "=+-*/;(){}:";
      blanks = " \t\015\n";

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all keywords, every one-byte token, skipped blanks, a number cut
      // short by a letter, and last on a byte that both ends a number and emits.
      send_text("let=var;fn\n_Z9\t0x\015:(){}+-*9/", 1'b1);
      // Zero byte with last while an identifier is open: flush it, then one EOF only.
      send_text("q", 1'b0);
      send_byte(CH_NUL, 1'b1);
      // Dropped byte with last: EOF alone.
      send_byte(8'hC4, 1'b1);
      // Last on a digit that extends a number: append, then flush, then EOF.
      send_text("42", 1'b1);

      // Random sources built from well-formed pieces, with noise and early ends mixed in.
      squeeze_request = 1'b1;
      start_count     = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            case ($urandom_range(0, 2))
               0:       send_text("let", 1'b0);
               1:       send_text("var", 1'b0);
               default: send_text("fn", 1'b0);
            endcase
         end else if (pick < 30) begin
            send_byte(alnum[$urandom_range(0, 52)], 1'b0);
            n = $urandom_range(0, 11);
            repeat (n) send_byte(alnum[$urandom_range(0, 62)], 1'b0);
         end else if (pick < 45) begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(alnum[$urandom_range(53, 62)], 1'b0);
         end else if (pick < 65) begin
            send_byte(puncts[$urandom_range(0, 10)], 1'b0);
         end else if (pick < 80) begin
            send_byte(blanks[$urandom_range(0, 3)], 1'b0);
         end else if (pick < 90) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
         end else if (pick < 95) begin
            send_byte(CH_NUL, 1'($urandom_range(0, 1)));
         end else begin
            send_byte(8'($urandom_range(1, 255)), 1'b1);
         end
      end

      // Long tokens: the text is cut to its first bytes and the truncated flag set;
      // the closing semicolon with last gives three tokens from one byte.
      send_byte("L", 1'b0);
      repeat (LONG_TAIL) send_byte(alnum[$urandom_range(0, 62)], 1'b0);
      send_byte(" ", 1'b0);
      repeat (LONG_TAIL) send_byte(alnum[$urandom_range(53, 62)], 1'b0);
      send_byte(";", 1'b1);

      // A final one-letter token ended by last.
      send_text("z", 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Drain every predicted token, then keep the clock running so stray outputs can show.
      while (pending_tokens != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
rtl/kit_pkg.sv
rtl/kit_front.sv
rtl/kit_queue.sv
rtl/kit_back.sv
rtl/keyword_identifier_tokenizer.sv
verif/keyword_identifier_tokenizer_checker.sv
verif/keyword_identifier_tokenizer_tb.sv
